// File: hdl/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

  // Frame-end status codes.
  typedef enum logic [1:0] {
    StatusGood     = 2'd0,
    StatusRunCut   = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  // Header classification reported with each frame end.
  typedef enum logic [1:0] {
    KindRequest = 2'd0,
    KindReply   = 2'd1,
    KindOther   = 2'd2,
    KindShort   = 2'd3
  } kind_e;

  localparam int unsigned LenW = 11;
  localparam logic [7:0] TypeRequest = 8'h50;
  localparam logic [7:0] TypeReply = 8'h51;
  localparam logic [LenW-1:0] HeaderBytes = LenW'(4);
  localparam logic [LenW-1:0] CapacityReset = LenW'(256);

  // Depth of the queue between the decoder and the output stage.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  // One classified word passed from the decoder to the output stage.
  typedef struct packed {
    logic            is_end;
    logic [7:0]      data;
    status_e         status;
    logic [LenW-1:0] length;
    logic [7:0]      type_byte;
    logic [7:0]      request;
    logic [7:0]      channel;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/cobs_frame_decoder_unit.sv
// COBS frame decoder.
// Input: one line byte per word on rx_byte_i, written with push while full is
// low. A zero byte delimits frames. Output: read like a queue; while empty is
// low the oldest word is on the result ports and pop takes it. A word is
// either one decoded payload byte (is_frame_end_o low) or a frame-end report
// with status, length, header kind, request id and channel id.
// Configuration: cfg_data_i is the frame capacity, written when cfg_valid_i
// is high; cfg_ready_o is always high. Write it only while the block is idle.
// Throughput is one byte per cycle while full is low. Each word goes first
// into a four-word queue, which the decoder writes at the edge that accepts
// its byte, and from there into the output stage's register.
// When the reader stalls the queue fills; full rises once it holds four
// words, and input then waits. Bytes that make no word still need a free slot.
// Reset clears the decoder to idle, empties the queue and the output stage,
// and sets the capacity to 256.
`default_nettype none

module cobs_frame_decoder_unit #(
  parameter int unsigned MaxFrameBytes = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [cfd_pkg::LenW-1:0] cfg_data_i,
  input  wire logic                     push,
  output      logic                     full,
  input  wire logic [7:0]               rx_byte_i,
  output      logic                     empty,
  input  wire logic                     pop,
  output      logic                     is_frame_end_o,
  output      logic [7:0]               data_byte_o,
  output      logic [1:0]               frame_status_o,
  output      logic [cfd_pkg::LenW-1:0] frame_length_o,
  output      logic [1:0]               frame_kind_o,
  output      logic [7:0]               request_id_o,
  output      logic [7:0]               channel_id_o
);
  import cfd_pkg::*;

  logic    accept;
  logic    q_wr;
  result_t q_wr_word;
  logic    q_rd;
  result_t q_rd_word;
  logic    q_full;
  logic    q_empty;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  // Decoder: runs the frame state and classifies each byte.
  cfd_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i,
    .accept_i  (accept),
    .byte_i    (rx_byte_i),
    .wr_o      (q_wr),
    .word_o    (q_wr_word)
  );

  // Short queue between decoder and output stage.
  cfd_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i      (q_wr),
    .wr_word_i (q_wr_word),
    .rd_i      (q_rd),
    .rd_word_o (q_rd_word),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // Output stage: formats the report and holds it for the reader.
  cfd_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .q_word_i  (q_rd_word),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .is_frame_end_o,
    .data_byte_o,
    .frame_status_o,
    .frame_length_o,
    .frame_kind_o,
    .request_id_o,
    .channel_id_o
  );

endmodule

`default_nettype wire

// File: hdl/cfd_front.sv
`default_nettype none

module cfd_front #(
  parameter int unsigned MaxFrameBytes = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [cfd_pkg::LenW-1:0] cfg_data_i,
  input  wire logic                     accept_i,
  input  wire logic [7:0]               byte_i,
  output      logic                     wr_o,
  output      cfd_pkg::result_t         word_o
);
  import cfd_pkg::*;

  localparam int unsigned MaxW = $clog2(MaxFrameBytes + 1);
  localparam int unsigned CntW = (MaxW > LenW) ? LenW : MaxW;
  localparam int unsigned CmpW = (MaxW > LenW) ? MaxW : LenW;

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeDecode = 2'd1,
    ModeAbort  = 2'd2
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [7:0]       run_q, run_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       req_q, req_d;
  logic [7:0]       chan_q, chan_d;
  logic [LenW-1:0]  cap_q;
  logic [CmpW-1:0]  limit;
  logic             at_limit;
  logic             is_zero;
  logic [7:0]       value;

  // The limit in force is the smaller of the register and the build maximum.
  assign limit = (CmpW'(cap_q) > CmpW'(MaxFrameBytes)) ? CmpW'(MaxFrameBytes)
                                                       : CmpW'(cap_q);
  assign at_limit = CmpW'(cnt_q) >= limit;
  assign is_zero = byte_i == 8'h00;
  // A code byte decodes to a zero; otherwise the byte passes through.
  assign value = (run_q == 8'h00) ? 8'h00 : byte_i;

  // Decoder next state and classified word for each accepted byte.
  always_comb begin
    mode_d = mode_q;
    run_d  = run_q;
    cnt_d  = cnt_q;
    type_d = type_q;
    req_d  = req_q;
    chan_d = chan_q;
    wr_o   = 1'b0;
    word_o = '0;
    word_o.length    = LenW'(cnt_q);
    word_o.type_byte = type_q;
    word_o.request   = req_q;
    word_o.channel   = chan_q;
    if (accept_i) begin
      unique case (mode_q)
        ModeDecode: begin
          if (is_zero) begin
            mode_d = ModeIdle;
            wr_o = 1'b1;
            word_o.is_end = 1'b1;
            word_o.status = (run_q == 8'h00) ? StatusGood : StatusRunCut;
          end else if (at_limit) begin
            mode_d = ModeAbort;
          end else begin
            run_d = (run_q == 8'h00) ? byte_i - 8'd1 : run_q - 8'd1;
            if (cnt_q == CntW'(0)) type_d = value;
            if (cnt_q == CntW'(1)) req_d = value;
            if (cnt_q == CntW'(2)) chan_d = value;
            cnt_d = cnt_q + CntW'(1);
            wr_o = 1'b1;
            word_o.data = value;
          end
        end
        ModeAbort: begin
          if (is_zero) begin
            mode_d = ModeIdle;
            wr_o = 1'b1;
            word_o.is_end = 1'b1;
            word_o.status = StatusOverflow;
          end
        end
        default: begin
          mode_d = ModeIdle;
          if (!is_zero) begin
            mode_d = ModeDecode;
            run_d  = byte_i - 8'd1;
            cnt_d  = '0;
            type_d = 8'h00;
            req_d  = 8'h00;
            chan_d = 8'h00;
          end
        end
      endcase
    end
  end

  // Decoder state and the capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      run_q  <= 8'h00;
      cnt_q  <= '0;
      type_q <= 8'h00;
      req_q  <= 8'h00;
      chan_q <= 8'h00;
      cap_q  <= CapacityReset;
    end else begin
      mode_q <= mode_d;
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      type_q <= type_d;
      req_q  <= req_d;
      chan_q <= chan_d;
      if (cfg_we_i) cap_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/cfd_queue.sv
`default_nettype none

module cfd_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire cfd_pkg::result_t wr_word_i,
  input  wire logic             rd_i,
  output      cfd_pkg::result_t rd_word_o,
  output      logic             full_o,
  output      logic             empty_o
);
  import cfd_pkg::*;

  result_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign full_o    = count_q == (QueuePtrW + 1)'(QueueDepth);
  assign empty_o   = count_q == '0;
  assign rd_word_o = mem_q[rd_ptr_q];

  // Word storage; no reset needed on payload.
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_word_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      if (rd_i) rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      if (wr_i && !rd_i) count_q <= count_q + (QueuePtrW + 1)'(1);
      else if (rd_i && !wr_i) count_q <= count_q - (QueuePtrW + 1)'(1);
    end
  end

endmodule

`default_nettype wire

// File: hdl/cfd_back.sv
`default_nettype none

module cfd_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_empty_i,
  input  wire cfd_pkg::result_t         q_word_i,
  output      logic                     q_rd_o,
  input  wire logic                     pop_i,
  output      logic                     empty_o,
  output      logic                     is_frame_end_o,
  output      logic [7:0]               data_byte_o,
  output      logic [1:0]               frame_status_o,
  output      logic [cfd_pkg::LenW-1:0] frame_length_o,
  output      logic [1:0]               frame_kind_o,
  output      logic [7:0]               request_id_o,
  output      logic [7:0]               channel_id_o
);
  import cfd_pkg::*;

  logic  valid_q;
  logic  load;
  kind_e kind;

  // Take a word whenever the output register is free or being drained.
  assign load    = !q_empty_i && (!valid_q || pop_i);
  assign q_rd_o  = load;
  assign empty_o = !valid_q;

  // Classify the frame by its length and its type byte.
  always_comb begin
    if (q_word_i.length < HeaderBytes) kind = KindShort;
    else if (q_word_i.type_byte == TypeRequest) kind = KindRequest;
    else if (q_word_i.type_byte == TypeReply) kind = KindReply;
    else kind = KindOther;
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  // Output word; frame-end fields read zero in a data word and vice versa.
  always_ff @(posedge clk_i) begin
    if (load) begin
      is_frame_end_o <= q_word_i.is_end;
      if (q_word_i.is_end) begin
        data_byte_o    <= 8'h00;
        frame_status_o <= q_word_i.status;
        frame_length_o <= q_word_i.length;
        frame_kind_o   <= kind;
        request_id_o   <= q_word_i.request;
        channel_id_o   <= q_word_i.channel;
      end else begin
        data_byte_o    <= q_word_i.data;
        frame_status_o <= 2'd0;
        frame_length_o <= '0;
        frame_kind_o   <= 2'd0;
        request_id_o   <= 8'h00;
        channel_id_o   <= 8'h00;
      end
    end
  end

endmodule

`default_nettype wire
